>>> rtl/sntd_pkg.sv
`default_nettype none

package sntd_pkg;

  localparam int CountW = 6;
  localparam int LimitW = 16;
  localparam logic [LimitW-1:0] LimitReset = 16'd100;
  localparam logic [CountW-1:0] CountMax = 6'h3F;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_ON    = 3'd1,
    CMD_OFF   = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_MAP   = 3'd4,
    CMD_QUERY = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COUNT,
    ST_HOLD
  } fsm_e;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] note;
    logic [5:0] map_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       solenoid_bits;
    logic [CountW-1:0] active_count;
    logic              note_active;
    logic              note_mapped;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic              apply;
    cmd_e              cmd;
    logic [LimitW-1:0] limit;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/sntd_ram.sv
`default_nettype none

module sntd_ram #(
  parameter int W = 6,
  parameter int D = 128
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                    wdata,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sntd_cell.sv
`default_nettype none

module sntd_cell import sntd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic              hit,
  input  wire logic [CountW-1:0] count_in,
  output logic                   on,
  output logic      [CountW-1:0] count_out
);

  logic [LimitW-1:0] elapsed;
  logic [LimitW-1:0] elapsed_next;
  logic [LimitW-1:0] bump;
  logic              on_next;

  // saturating increment
  assign bump = (elapsed == '1) ? elapsed : elapsed + 16'd1;

  always_comb begin
    on_next      = on;
    elapsed_next = elapsed;
    if (ctrl.apply) begin
      unique case (ctrl.cmd)
        CMD_TICK: begin
          if (on) begin
            if (bump >= ctrl.limit) begin
              on_next      = 1'b0;
              elapsed_next = '0;
            end else begin
              elapsed_next = bump;
            end
          end
        end
        CMD_ON: begin
          if (hit) begin
            on_next      = 1'b1;
            elapsed_next = '0;
          end
        end
        CMD_OFF: begin
          if (hit) begin
            on_next      = 1'b0;
            elapsed_next = '0;
          end
        end
        CMD_CLEAR: begin
          on_next      = 1'b0;
          elapsed_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on      <= 1'b0;
      elapsed <= '0;
    end else begin
      on      <= on_next;
      elapsed <= elapsed_next;
    end
  end

  // running count, one cell further each cycle
  always_ff @(posedge clk) begin
    count_out <= (on && count_in != CountMax) ? count_in + 6'd1 : count_in;
  end

endmodule

`default_nettype wire

>>> rtl/solenoid_note_timeout_driver.sv
`default_nettype none

// Channel   Valid      Stall      Payload    Transaction
// input     in_valid   in_stall   in_data    one command item
// output    out_valid  out_stall  out_data   one result per command
// config    cfg_we     -          cfg_data   on-time limit write
//
// An item is accepted in an idle cycle; its map RAM read lands in the next
// cycle, which applies the command to the cells. The FSM then stays in ST_COUNT
// while the active count ripples down the cell row, and the result loads at the
// end of ST_COUNT, or from ST_HOLD once the output is free. in_stall is low
// only when idle; a stalled result waits in the output register while the next
// item runs. Synchronous rst clears out_valid and map valid bits, loads LimitReset.
module solenoid_note_timeout_driver import sntd_pkg::*; #(
  parameter int OUTPUT_COUNT = 32,
  parameter int NOTE_COUNT   = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [LimitW-1:0] cfg_data
);

  localparam int AW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int CW = $clog2(OUTPUT_COUNT + 1);

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  logic [LimitW-1:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LimitReset;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  fsm_e          state;
  fsm_e          state_next;
  logic [CW-1:0] wcnt;
  logic [CW-1:0] wcnt_next;
  logic          accept;
  logic          apply;
  logic          load;
  logic          count_done;
  logic          out_free;

  assign accept     = in_valid && !in_stall;
  assign count_done = (wcnt == CW'(OUTPUT_COUNT));
  assign out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wcnt  <= '0;
    end else begin
      state <= state_next;
      wcnt  <= wcnt_next;
    end
  end

  always_comb begin
    state_next = state;
    wcnt_next  = wcnt;
    in_stall   = 1'b1;
    apply      = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // map data is back; update the cells this cycle
        apply      = 1'b1;
        wcnt_next  = '0;
        state_next = ST_COUNT;
      end
      ST_COUNT: begin
        if (count_done) begin
          if (out_free) begin
            load       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end else begin
          wcnt_next = wcnt + CW'(1);
        end
      end
      ST_HOLD: begin
        // count chain is settled and holds while cells stay unchanged
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // captured item
  // ---------------------------------------------------------------------
  cmd_e       cmd_q;
  logic [6:0] note_q;
  logic [5:0] mval_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_e'(in_data.command);
      note_q <= in_data.note;
      mval_q <= in_data.map_value;
    end
  end

  // ---------------------------------------------------------------------
  // note map: RAM plus one valid bit per entry (reset reads as unmapped)
  // ---------------------------------------------------------------------
  logic [NOTE_COUNT-1:0] map_vld;
  logic [AW-1:0]         addr_q;
  logic [5:0]            rd_data;
  logic                  in_range;
  logic                  map_we;
  logic [5:0]            map_v;
  logic                  look_mapped;

  assign addr_q   = AW'(note_q);
  assign in_range = {2'b00, note_q} < 9'(NOTE_COUNT);
  assign map_we   = apply && (cmd_q == CMD_MAP) && in_range;

  sntd_ram #(
    .W(6),
    .D(NOTE_COUNT)
  ) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(addr_q),
    .wdata(mval_q),
    .raddr(AW'(in_data.note)),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
    end else if (map_we) begin
      map_vld[addr_q] <= 1'b1;
    end
  end

  assign map_v = (in_range && map_vld[addr_q]) ? rd_data : 6'd0;
  // entries past the last output act as unmapped
  assign look_mapped = (map_v != 6'd0) && ({1'b0, map_v} <= 7'(OUTPUT_COUNT));

  // ---------------------------------------------------------------------
  // cell row
  // ---------------------------------------------------------------------
  cell_ctrl_t              ctrl;
  logic [OUTPUT_COUNT-1:0] hits;
  logic [OUTPUT_COUNT-1:0] on_vec;
  logic [CountW-1:0]       cnt [OUTPUT_COUNT];

  assign ctrl.apply = apply;
  assign ctrl.cmd   = cmd_q;
  assign ctrl.limit = limit;

  for (genvar i = 0; i < OUTPUT_COUNT; i++) begin : g_cell
    logic [CountW-1:0] cin;

    assign hits[i] = look_mapped && ({1'b0, map_v} == 7'(i + 1));

    if (i == 0) begin : g_first
      assign cin = '0;
    end else begin : g_rest
      assign cin = cnt[i-1];
    end

    sntd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .hit      (hits[i]),
      .count_in (cin),
      .on       (on_vec[i]),
      .count_out(cnt[i])
    );
  end

  // only the first 32 outputs are visible in the bit field
  logic [31:0] bits_vec;

  for (genvar b = 0; b < 32; b++) begin : g_bits
    if (b < OUTPUT_COUNT) begin : g_used
      assign bits_vec[b] = on_vec[b];
    end else begin : g_unused
      assign bits_vec[b] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // per-item flags, taken in the apply cycle
  // ---------------------------------------------------------------------
  logic mapped_res;
  logic active_q;
  logic mapped_q;

  always_comb begin
    case (cmd_q) inside
      CMD_ON, CMD_OFF, CMD_QUERY: mapped_res = look_mapped;
      CMD_MAP: mapped_res = in_range && (mval_q != 6'd0) &&
                            ({1'b0, mval_q} <= 7'(OUTPUT_COUNT));
      default: mapped_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      mapped_q <= mapped_res;
      active_q <= (cmd_q == CMD_QUERY) && |(on_vec & hits);
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.solenoid_bits <= bits_vec;
      out_data.active_count  <= cnt[OUTPUT_COUNT-1];
      out_data.note_active   <= active_q;
      out_data.note_mapped   <= mapped_q;
    end
  end

endmodule

`default_nettype wire
